// ----- rtl/sdbe_pkg.sv -----
// Shared types, action codes and segment tables for the segment display buffer engine.
package sdbe_pkg;

    localparam int DIGIT_POSITIONS = 5;
    localparam int SEGS_PER_DIGIT  = 11;
    localparam int SHAPE_COUNT     = 13;
    localparam int SHAPE_SEG_COUNT = 50;

    localparam logic [1:0] ACT_CLEAR_SCREEN = 2'd0;
    localparam logic [1:0] ACT_DRAW_DIGIT   = 2'd1;
    localparam logic [1:0] ACT_SET_SHAPE    = 2'd2;
    localparam logic [1:0] ACT_CLEAR_SHAPE  = 2'd3;

    typedef struct packed {
        logic [4:0] byte_ix;
        logic [2:0] bit_ix;
    } t_seg_loc;

    typedef struct packed {
        logic       shape_mode;
        logic [3:0] digit;
        logic [3:0] target;
        logic [4:0] step;
    } t_seq_ctl;

    typedef struct packed {
        logic     en;
        t_seg_loc loc;
    } t_seg_cmd;

    localparam logic [10:0] DIGIT_MASKS [16] = '{
        11'h3FF, 11'h00E, 11'h6F7, 11'h63F, 11'h78E, 11'h7BD, 11'h7FD, 11'h20F,
        11'h7FF, 11'h7BF, 11'h7EF, 11'h7FC, 11'h4F0, 11'h4FE, 11'h7F1, 11'h7E1
    };

    localparam t_seg_loc POS_MAP [DIGIT_POSITIONS][SEGS_PER_DIGIT] = '{
        '{'{5'd16, 3'd7}, '{5'd15, 3'd4}, '{5'd14, 3'd1}, '{5'd14, 3'd7}, '{5'd12, 3'd5},
          '{5'd12, 3'd4}, '{5'd13, 3'd3}, '{5'd15, 3'd7}, '{5'd15, 3'd6}, '{5'd15, 3'd5},
          '{5'd14, 3'd0}},
        '{'{5'd15, 3'd0}, '{5'd15, 3'd1}, '{5'd14, 3'd6}, '{5'd13, 3'd0}, '{5'd13, 3'd5},
          '{5'd13, 3'd4}, '{5'd14, 3'd5}, '{5'd14, 3'd4}, '{5'd15, 3'd3}, '{5'd15, 3'd2},
          '{5'd14, 3'd3}},
        '{'{5'd13, 3'd1}, '{5'd13, 3'd7}, '{5'd12, 3'd1}, '{5'd12, 3'd7}, '{5'd11, 3'd5},
          '{5'd11, 3'd2}, '{5'd12, 3'd6}, '{5'd12, 3'd0}, '{5'd13, 3'd6}, '{5'd13, 3'd2},
          '{5'd12, 3'd2}},
        '{'{5'd9, 3'd1}, '{5'd9, 3'd7}, '{5'd8, 3'd5}, '{5'd1, 3'd1}, '{5'd0, 3'd3},
          '{5'd1, 3'd4}, '{5'd9, 3'd4}, '{5'd10, 3'd0}, '{5'd10, 3'd6}, '{5'd10, 3'd3},
          '{5'd8, 3'd2}},
        '{'{5'd7, 3'd7}, '{5'd6, 3'd5}, '{5'd2, 3'd0}, '{5'd2, 3'd3}, '{5'd0, 3'd2},
          '{5'd1, 3'd7}, '{5'd2, 3'd6}, '{5'd7, 3'd4}, '{5'd7, 3'd1}, '{5'd8, 3'd6},
          '{5'd6, 3'd2}}
    };

    localparam t_seg_loc SHAPE_SEGS [SHAPE_SEG_COUNT] = '{
        '{5'd12, 3'd3},
        '{5'd16, 3'd4},
        '{5'd16, 3'd6}, '{5'd14, 3'd2},
        '{5'd3, 3'd5}, '{5'd5, 3'd3}, '{5'd5, 3'd6}, '{5'd4, 3'd1}, '{5'd4, 3'd4},
        '{5'd4, 3'd7}, '{5'd3, 3'd2},
        '{5'd4, 3'd1}, '{5'd5, 3'd6}, '{5'd3, 3'd2}, '{5'd4, 3'd7},
        '{5'd5, 3'd6}, '{5'd4, 3'd4}, '{5'd4, 3'd1},
        '{5'd5, 3'd6}, '{5'd4, 3'd1}, '{5'd4, 3'd7},
        '{5'd5, 3'd0},
        '{5'd16, 3'd5},
        '{5'd14, 3'd2},
        '{5'd16, 3'd6},
        '{5'd14, 3'd0},
        '{5'd16, 3'd7}, '{5'd15, 3'd4}, '{5'd14, 3'd1}, '{5'd14, 3'd7}, '{5'd12, 3'd4},
        '{5'd13, 3'd3}, '{5'd15, 3'd7}, '{5'd15, 3'd6}, '{5'd15, 3'd5}, '{5'd14, 3'd0},
        '{5'd13, 3'd5}, '{5'd13, 3'd4}, '{5'd14, 3'd5}, '{5'd14, 3'd4}, '{5'd15, 3'd3},
        '{5'd15, 3'd2}, '{5'd14, 3'd3}, '{5'd13, 3'd1}, '{5'd11, 3'd5}, '{5'd11, 3'd2},
        '{5'd12, 3'd6}, '{5'd12, 3'd0}, '{5'd13, 3'd6}, '{5'd13, 3'd2}
    };

    localparam logic [5:0] SHAPE_START [SHAPE_COUNT] = '{
        6'd0, 6'd1, 6'd2, 6'd4, 6'd11, 6'd15, 6'd18, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26
    };

    localparam logic [4:0] SHAPE_LEN [SHAPE_COUNT] = '{
        5'd1, 5'd1, 5'd2, 5'd7, 5'd4, 5'd3, 5'd3, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd24
    };

endpackage

// ----- rtl/sdbe_seg_lookup.sv -----
// Segment lookup: maps the sequencer step of a digit or shape to one frame bit.
module sdbe_seg_lookup (
    input  sdbe_pkg::t_seq_ctl i_ctl,
    output sdbe_pkg::t_seg_cmd o_cmd
);

    logic [10:0] w_mask;
    logic [5:0]  w_shape_ix;

    assign w_mask     = sdbe_pkg::DIGIT_MASKS[i_ctl.digit];
    assign w_shape_ix = sdbe_pkg::SHAPE_START[i_ctl.target] + 6'(i_ctl.step);

    always_comb begin
        if (i_ctl.shape_mode) begin
            o_cmd.en  = 1'b1;
            o_cmd.loc = sdbe_pkg::SHAPE_SEGS[w_shape_ix];
        end else begin
            o_cmd.en  = w_mask[i_ctl.step[3:0]];
            o_cmd.loc = sdbe_pkg::POS_MAP[i_ctl.target[2:0]][i_ctl.step[3:0]];
        end
    end

endmodule

// ----- rtl/segment_display_buffer_engine_core.sv -----
// Top level of the segment display buffer engine: frame registers and bit-update sequencer.
//
// Usage:
//   Slave channel (i_s_tvalid / o_s_tready / i_s_tdata) takes one command per
//   transaction: clear screen, draw a hex digit, set a shape or clear a shape,
//   plus the index of the frame byte to report. Master channel (o_m_tvalid /
//   i_m_tready / o_m_tdata) returns that frame byte after the update, one
//   transaction per command.
//   A single read-modify-write bit unit updates one segment per cycle under a
//   step counter: a digit takes 11 steps, a shape 1 to 24 steps, a clear or an
//   out-of-range target none. After the steps the sequencer registers the
//   reported byte and raises o_m_tvalid; one command is in flight at a time.
//   o_s_tready is high only while idle. When the receiver stalls, the result
//   holds on o_m_tdata and no new command is taken until it is delivered.
//   Reset clears the frame to all zero and returns the sequencer to idle.
module segment_display_buffer_engine_core #(
    parameter int BUFFER_BYTES = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // action[1:0], digit[5:2], target[9:6], read_index[14:10]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // byte_value[7:0]
);

    localparam int         IxW      = $clog2(BUFFER_BYTES);
    localparam logic [5:0] BufBytes = 6'(BUFFER_BYTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [4:0] r_step, n_step;
    logic [4:0] r_last, n_last;
    logic [1:0] r_action;
    logic [3:0] r_digit;
    logic [3:0] r_target;
    logic [4:0] r_rix;
    logic [7:0] r_out;
    logic [7:0] r_buf [BUFFER_BYTES];

    logic [1:0] w_action;
    logic [3:0] w_target;
    logic       w_accept;
    logic       w_clear;
    logic       w_seg_ok;
    logic       w_rd_ok;
    logic [4:0] w_rd_addr;
    logic [7:0] w_rd_byte;
    logic [7:0] w_wr_byte;
    logic [7:0] w_bit;

    sdbe_pkg::t_seq_ctl w_ctl;
    sdbe_pkg::t_seg_cmd w_cmd;

    assign w_action = i_s_tdata[1:0];
    assign w_target = i_s_tdata[9:6];
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_clear  = w_accept && (w_action == sdbe_pkg::ACT_CLEAR_SCREEN);

    assign w_ctl.shape_mode = (r_action != sdbe_pkg::ACT_DRAW_DIGIT);
    assign w_ctl.digit      = r_digit;
    assign w_ctl.target     = r_target;
    assign w_ctl.step       = r_step;

    sdbe_seg_lookup u_lookup (
        .i_ctl (w_ctl),
        .o_cmd (w_cmd)
    );

    assign w_rd_addr = (r_state == ST_READ) ? r_rix : w_cmd.loc.byte_ix;
    assign w_rd_ok   = ({1'b0, w_rd_addr} < BufBytes);
    assign w_rd_byte = w_rd_ok ? r_buf[w_rd_addr[IxW-1:0]] : 8'd0;
    assign w_seg_ok  = (r_state == ST_RUN) && w_cmd.en && w_rd_ok;
    assign w_bit     = 8'(1) << w_cmd.loc.bit_ix;
    assign w_wr_byte = (r_action == sdbe_pkg::ACT_CLEAR_SHAPE) ? (w_rd_byte & ~w_bit)
                                                              : (w_rd_byte | w_bit);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_last  = r_last;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_step  = 5'd0;
                    n_state = ST_READ;
                    case (w_action)
                        sdbe_pkg::ACT_CLEAR_SCREEN: begin
                            n_state = ST_READ;
                        end
                        sdbe_pkg::ACT_DRAW_DIGIT: begin
                            if (5'(w_target) < 5'(sdbe_pkg::DIGIT_POSITIONS)) begin
                                n_state = ST_RUN;
                                n_last  = 5'(sdbe_pkg::SEGS_PER_DIGIT - 1);
                            end
                        end
                        default: begin
                            if (5'(w_target) < 5'(sdbe_pkg::SHAPE_COUNT)) begin
                                n_state = ST_RUN;
                                n_last  = sdbe_pkg::SHAPE_LEN[w_target] - 5'd1;
                            end
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (r_step == r_last) begin
                    n_state = ST_READ;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 5'd0;
            r_last  <= 5'd0;
            for (int i = 0; i < BUFFER_BYTES; i++) begin
                r_buf[i] <= 8'd0;
            end
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_last  <= n_last;
            if (w_clear) begin
                for (int i = 0; i < BUFFER_BYTES; i++) begin
                    r_buf[i] <= 8'd0;
                end
            end else if (w_seg_ok) begin
                r_buf[w_rd_addr[IxW-1:0]] <= w_wr_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= w_action;
            r_digit  <= i_s_tdata[5:2];
            r_target <= w_target;
            r_rix    <= i_s_tdata[14:10];
        end
        if (r_state == ST_READ) begin
            r_out <= w_rd_byte;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_m_tdata  = r_out;

endmodule

// ----- test/segment_display_buffer_engine_core_test.sv -----
// Self-checking testbench for the segment display buffer engine: directed and random commands.
module segment_display_buffer_engine_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BYTES = 18;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [3:0] POS_TOP_LEFT     = 4'd0;
    localparam logic [3:0] POS_TOP_MIDDLE   = 4'd1;
    localparam logic [3:0] POS_TOP_RIGHT    = 4'd2;
    localparam logic [3:0] POS_BOTTOM_LEFT  = 4'd3;
    localparam logic [3:0] POS_BOTTOM_RIGHT = 4'd4;

    localparam logic [3:0] SHAPE_TOP_LEFT_ONE = 4'd0;
    localparam logic [3:0] SHAPE_FACE         = 4'd3;
    localparam logic [3:0] SHAPE_SMILE        = 4'd4;
    localparam logic [3:0] SHAPE_SUN          = 4'd7;
    localparam logic [3:0] SHAPE_BANNER       = 4'd12;

    // Segment k of each hex digit is lit when bit k is set.
    localparam logic [10:0] LIT_SEGMENTS [16] = '{
        11'h3FF, 11'h00E, 11'h6F7, 11'h63F, 11'h78E, 11'h7BD, 11'h7FD, 11'h20F,
        11'h7FF, 11'h7BF, 11'h7EF, 11'h7FC, 11'h4F0, 11'h4FE, 11'h7F1, 11'h7E1
    };

    // Segment locations below are coded as byte * 8 + bit.
    localparam int POSITION_SEGS [5][11] = '{
        '{135, 124, 113, 119, 101, 100, 107, 127, 126, 125, 112},
        '{120, 121, 118, 104, 109, 108, 117, 116, 123, 122, 115},
        '{105, 111,  97, 103,  93,  90, 102,  96, 110, 106,  98},
        '{ 73,  79,  69,   9,   3,  12,  76,  80,  86,  83,  66},
        '{ 63,  53,  16,  19,   2,  15,  22,  60,  57,  70,  50}
    };

    localparam int SHAPE_LIST [50] = '{
        99,
        132,
        134, 114,
        29, 43, 46, 33, 36, 39, 26,
        33, 46, 26, 39,
        46, 36, 33,
        46, 33, 39,
        40,
        133,
        114,
        134,
        112,
        135, 124, 113, 119, 100, 107, 127, 126, 125, 112,
        109, 108, 117, 116, 123, 122, 115, 105,  93,  90,
        102,  96, 110, 106
    };

    localparam int SHAPE_FIRST [13] = '{0, 1, 2, 4, 11, 15, 18, 21, 22, 23, 24, 25, 26};
    localparam int SHAPE_SIZE  [13] = '{1, 1, 2, 7, 4, 3, 3, 1, 1, 1, 1, 1, 24};

    class frame_scoreboard;
        logic [7:0] frame [FRAME_BYTES];
        logic [7:0] pending_bytes [$];
        int errors;

        function new();
            clear_frame();
            errors = 0;
        endfunction

        function void clear_frame();
            foreach (frame[i]) frame[i] = 8'h00;
        endfunction

        function void write_segment(int seg, bit on);
            int byte_ix;
            int bit_ix;
            byte_ix = seg / 8;
            bit_ix = seg % 8;
            if (byte_ix < FRAME_BYTES) begin
                frame[byte_ix][bit_ix] = on;
            end
        endfunction

        function void note_command(logic [1:0] action, logic [3:0] digit,
                                   logic [3:0] target, logic [4:0] read_index);
            case (action)
                sdbe_pkg::ACT_CLEAR_SCREEN: begin
                    clear_frame();
                end
                sdbe_pkg::ACT_DRAW_DIGIT: begin
                    if (target < sdbe_pkg::DIGIT_POSITIONS) begin
                        for (int k = 0; k < sdbe_pkg::SEGS_PER_DIGIT; k++) begin
                            if (LIT_SEGMENTS[digit][k]) begin
                                write_segment(POSITION_SEGS[target][k], 1'b1);
                            end
                        end
                    end
                end
                default: begin
                    if (target < sdbe_pkg::SHAPE_COUNT) begin
                        for (int k = 0; k < SHAPE_SIZE[target]; k++) begin
                            write_segment(SHAPE_LIST[SHAPE_FIRST[target] + k],
                                          action == sdbe_pkg::ACT_SET_SHAPE);
                        end
                    end
                end
            endcase
            pending_bytes.push_back(read_index < FRAME_BYTES ? frame[read_index] : 8'h00);
        endfunction

        function void check_byte(logic [7:0] actual);
            logic [7:0] expected;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h", $time, actual);
                errors++;
            end else begin
                expected = pending_bytes.pop_front();
                if (actual !== expected) begin
                    $display("%0t: byte_value mismatch, expected %02h, actual %02h",
                             $time, expected, actual);
                    errors++;
                end
            end
        endfunction

        function int pending_count();
            return pending_bytes.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = 16'h0000;  // action[1:0], digit[5:2], target[9:6], read_index[14:10]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;             // byte_value[7:0]

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    frame_scoreboard board;

    segment_display_buffer_engine_core #(
        .BUFFER_BYTES(FRAME_BYTES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_byte(o_m_tdata);
        end
    end

    task automatic send_command(input logic [1:0] action, input logic [3:0] digit,
                                input logic [3:0] target, input logic [4:0] read_index);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= 16'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {1'b0, read_index, target, digit, action};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_command(action, digit, target, read_index);
    endtask

    task automatic send_random_commands(input int count);
        int roll;
        logic [1:0] action;
        logic [3:0] digit;
        logic [3:0] target;
        logic [4:0] read_index;
        repeat (count) begin
            roll = $urandom_range(99);
            action = roll < 5  ? sdbe_pkg::ACT_CLEAR_SCREEN :
                     roll < 40 ? sdbe_pkg::ACT_DRAW_DIGIT :
                     roll < 75 ? sdbe_pkg::ACT_SET_SHAPE : sdbe_pkg::ACT_CLEAR_SHAPE;
            digit = 4'($urandom_range(15));
            if ($urandom_range(9) == 0) begin
                target = 4'($urandom_range(15));
            end else if (action == sdbe_pkg::ACT_DRAW_DIGIT) begin
                target = 4'($urandom_range(sdbe_pkg::DIGIT_POSITIONS - 1));
            end else begin
                target = 4'($urandom_range(sdbe_pkg::SHAPE_COUNT - 1));
            end
            if ($urandom_range(9) == 0) begin
                read_index = 5'($urandom_range(31));
            end else begin
                read_index = 5'($urandom_range(FRAME_BYTES - 1));
            end
            send_command(action, digit, target, read_index);
        end
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 79;
        send_command(sdbe_pkg::ACT_CLEAR_SCREEN, 4'd15, 4'd15, 5'd31);
        send_command(sdbe_pkg::ACT_DRAW_DIGIT, 4'd8, POS_TOP_LEFT, 5'd16);
        send_command(sdbe_pkg::ACT_DRAW_DIGIT, 4'd0, POS_BOTTOM_RIGHT, 5'd0);
        send_command(sdbe_pkg::ACT_DRAW_DIGIT, 4'd15, 4'(sdbe_pkg::DIGIT_POSITIONS), 5'd15);
        send_command(sdbe_pkg::ACT_DRAW_DIGIT, 4'd1, 4'd15, 5'd14);
        send_command(sdbe_pkg::ACT_SET_SHAPE, 4'd0, SHAPE_BANNER, 5'd13);
        send_command(sdbe_pkg::ACT_CLEAR_SHAPE, 4'd0, SHAPE_BANNER, 5'd14);
        send_command(sdbe_pkg::ACT_SET_SHAPE, 4'd15, SHAPE_FACE, 5'd4);
        send_command(sdbe_pkg::ACT_CLEAR_SHAPE, 4'd15, SHAPE_SMILE, 5'd5);
        send_command(sdbe_pkg::ACT_SET_SHAPE, 4'd0, 4'(sdbe_pkg::SHAPE_COUNT), 5'd3);
        send_command(sdbe_pkg::ACT_CLEAR_SHAPE, 4'd0, 4'd15, 5'd5);
        send_command(sdbe_pkg::ACT_SET_SHAPE, 4'd9, SHAPE_TOP_LEFT_ONE, 5'd12);
        send_command(sdbe_pkg::ACT_DRAW_DIGIT, 4'd10, POS_TOP_RIGHT, 5'd17);
        send_command(sdbe_pkg::ACT_DRAW_DIGIT, 4'd12, POS_BOTTOM_LEFT, 5'd9);
        send_command(sdbe_pkg::ACT_DRAW_DIGIT, 4'd15, POS_TOP_MIDDLE, 5'd18);
        send_command(sdbe_pkg::ACT_SET_SHAPE, 4'd0, SHAPE_SUN, 5'd5);
        send_command(sdbe_pkg::ACT_CLEAR_SHAPE, 4'd0, SHAPE_TOP_LEFT_ONE, 5'd12);
        send_command(sdbe_pkg::ACT_DRAW_DIGIT, 4'd7, POS_BOTTOM_RIGHT, 5'd7);
        send_command(sdbe_pkg::ACT_CLEAR_SCREEN, 4'd0, 4'd0, 5'd17);
        send_random_commands(330);

        send_idle_pct = 79;
        recv_idle_pct = 21;
        send_random_commands(330);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_commands(340);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (board.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
